// ----- src/jsu_pkg.sv -----
// ============================================================================
// jsu_pkg
// Shared types for the JSON string unescape block: channel payloads and
// result kind codes.
// ============================================================================
`timescale 1ns / 1ps

package jsu_pkg;

   // Result kind carried with every output transaction
   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_DONE = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] text_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } rsp_payload_type;

endpackage

// ----- src/jsu_stream_if.sv -----
// ============================================================================
// jsu_stream_if
// Valid/ready stream channel; a transaction moves when valid and ready are
// both high at a rising clock edge.
// ============================================================================
`timescale 1ns / 1ps

interface jsu_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/json_string_unescape_utf8.sv -----
// ============================================================================
// json_string_unescape_utf8
// Results of a byte enter the result queue when its transaction is taken and
// are offered from the queue head. Throughput: one input byte per cycle while
// the 8-entry result queue holds at most 4 entries; the output drains one result per
// cycle while rsp ready is high, so multi-byte UTF-8 escapes are output-paced.
// Reset (synchronous): idle awaiting the opening quote, result queue empty.
// ============================================================================
`timescale 1ns / 1ps

module json_string_unescape_utf8 (
   input  logic             clock,
   input  logic             reset,
   jsu_stream_if.sink       req_if,
   jsu_stream_if.source     rsp_if
);

   // Result queue geometry: one input byte makes at most GROUP_MAX results
   localparam int FIFO_DEPTH = 8;
   localparam int GROUP_MAX  = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Characters of interest
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [20:0] CP_REPL  = 21'h00FFFD;
   localparam logic [20:0] CP_SUPP  = 21'h010000;

   // Decoder phase
   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_BODY        = 3'd1,
      PH_ESC         = 3'd2,
      PH_HEX1        = 3'd3,
      PH_AFTER_HI    = 3'd4,
      PH_AFTER_HI_BS = 3'd5,
      PH_HEX2        = 3'd6
   } phase_type;

   // Outcome of handling one byte as string body or as escape letter
   typedef struct packed {
      logic             one_en;
      logic [7:0]       one_byte;
      jsu_pkg::kind_type kind;
      logic             to_idle;
      phase_type        next_phase;
   } step_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [2:0]      n;
      logic [3:0][7:0] bytes;
   } utf8_type;

   // --------------------------------------------------------------------------
   // Helpers
   // --------------------------------------------------------------------------
   function automatic hex_type nibble_of(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic step_type bad_step();
      step_type s;
      s = '{one_en: 1'b1, one_byte: 8'h00, kind: jsu_pkg::KIND_BAD,
            to_idle: 1'b1, next_phase: PH_IDLE};
      return s;
   endfunction

   // Plain string content: quote closes, control bytes are malformed
   function automatic step_type body_step(input logic [7:0] c);
      step_type s;
      s = '{one_en: 1'b0, one_byte: 8'h00, kind: jsu_pkg::KIND_BYTE,
            to_idle: 1'b0, next_phase: PH_BODY};
      priority if (c == CH_QUOTE) begin
         s.one_en  = 1'b1;
         s.kind    = jsu_pkg::KIND_DONE;
         s.to_idle = 1'b1;
      end else if (c < CH_SPACE) begin
         s = bad_step();
      end else if (c == CH_BSL) begin
         s.next_phase = PH_ESC;
      end else begin
         s.one_en   = 1'b1;
         s.one_byte = c;
      end
      return s;
   endfunction

   // Letter after a backslash
   function automatic step_type escape_step(input logic [7:0] c);
      step_type s;
      s = '{one_en: 1'b1, one_byte: 8'h00, kind: jsu_pkg::KIND_BYTE,
            to_idle: 1'b0, next_phase: PH_BODY};
      unique case (c)
         CH_QUOTE: s.one_byte = CH_QUOTE;
         CH_BSL:   s.one_byte = CH_BSL;
         CH_SLASH: s.one_byte = CH_SLASH;
         CH_B:     s.one_byte = 8'h08;
         CH_F:     s.one_byte = 8'h0C;
         CH_N:     s.one_byte = 8'h0A;
         CH_R:     s.one_byte = 8'h0D;
         CH_T:     s.one_byte = 8'h09;
         CH_U: begin
            s.one_en     = 1'b0;
            s.next_phase = PH_HEX1;
         end
         default:  s = bad_step();
      endcase
      return s;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type u;
      u.bytes = '0;
      if (cp <= 21'h7F) begin
         u.n        = 3'd1;
         u.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         u.n        = 3'd2;
         u.bytes[0] = {3'b110, cp[10:6]};
         u.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         u.n        = 3'd3;
         u.bytes[0] = {4'b1110, cp[15:12]};
         u.bytes[1] = {2'b10, cp[11:6]};
         u.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         u.n        = 3'd4;
         u.bytes[0] = {5'b11110, cp[20:18]};
         u.bytes[1] = {2'b10, cp[17:12]};
         u.bytes[2] = {2'b10, cp[11:6]};
         u.bytes[3] = {2'b10, cp[5:0]};
      end
      return u;
   endfunction

   // --------------------------------------------------------------------------
   // State
   // --------------------------------------------------------------------------
   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_acc_ff, code_acc_in;
   logic [9:0]  high_half_ff, high_half_in;

   // Result queue
   jsu_pkg::rsp_payload_type fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic req_take;
   logic rsp_take;

   // Decode outputs: an optional UTF-8 sequence followed by an optional
   // single result (byte, done or malformed)
   logic [7:0]        c;
   hex_type           hx;
   logic [15:0]       acc_next;
   logic              enc_en;
   logic [20:0]       enc_cp;
   step_type          st;
   logic              use_step;
   utf8_type          enc;
   logic [2:0]        enc_n;
   logic [2:0]        res_n;
   jsu_pkg::rsp_payload_type grp  [GROUP_MAX];
   logic [PTR_W-1:0]  wr_idx [GROUP_MAX];

   assign req_take = req_if.valid && req_if.ready;
   assign rsp_take = rsp_if.valid && rsp_if.ready;

   // Room for a full group of results
   assign req_if.ready   = (count_ff <= CNT_W'(FIFO_DEPTH - GROUP_MAX));
   assign rsp_if.valid   = (count_ff != '0);
   assign rsp_if.payload = fifo_ff[rd_ptr_ff];

   // --------------------------------------------------------------------------
   // Byte decode
   // --------------------------------------------------------------------------
   always_comb begin
      c            = req_if.payload.text_byte;
      hx           = nibble_of(c);
      acc_next     = {code_acc_ff[11:0], hx.value};
      phase_in     = phase_ff;
      hex_count_in = hex_count_ff;
      code_acc_in  = code_acc_ff;
      high_half_in = high_half_ff;
      enc_en       = 1'b0;
      enc_cp       = '0;
      use_step     = 1'b0;
      st           = bad_step();

      unique case (phase_ff)
         PH_BODY: begin
            use_step = 1'b1;
            st       = body_step(c);
         end
         PH_ESC: begin
            use_step = 1'b1;
            st       = escape_step(c);
         end
         PH_HEX1: begin
            if (!hx.ok) begin
               use_step = 1'b1;
            end else if (hex_count_ff == 2'd3) begin
               hex_count_in = '0;
               code_acc_in  = '0;
               if (acc_next >= 16'hD800 && acc_next <= 16'hDBFF) begin
                  high_half_in = acc_next[9:0];
                  phase_in     = PH_AFTER_HI;
               end else if (acc_next == 16'h0000) begin
                  // escaped NUL is malformed
                  use_step = 1'b1;
               end else begin
                  // a lone low surrogate becomes the replacement character
                  enc_en   = 1'b1;
                  enc_cp   = (acc_next >= 16'hDC00 && acc_next <= 16'hDFFF) ?
                             CP_REPL : {5'b0, acc_next};
                  phase_in = PH_BODY;
               end
            end else begin
               hex_count_in = hex_count_ff + 2'd1;
               code_acc_in  = acc_next;
            end
         end
         PH_AFTER_HI: begin
            if (c == CH_BSL) begin
               phase_in = PH_AFTER_HI_BS;
            end else begin
               // lone high surrogate, then the byte is ordinary content
               enc_en       = 1'b1;
               enc_cp       = CP_REPL;
               high_half_in = '0;
               use_step     = 1'b1;
               st           = body_step(c);
            end
         end
         PH_AFTER_HI_BS: begin
            if (c == CH_U) begin
               phase_in     = PH_HEX2;
               hex_count_in = '0;
               code_acc_in  = '0;
            end else begin
               enc_en       = 1'b1;
               enc_cp       = CP_REPL;
               high_half_in = '0;
               use_step     = 1'b1;
               st           = (c == 8'h00) ? bad_step() : escape_step(c);
            end
         end
         PH_HEX2: begin
            if (!hx.ok) begin
               use_step = 1'b1;
            end else if (hex_count_ff == 2'd3) begin
               hex_count_in = '0;
               code_acc_in  = '0;
               high_half_in = '0;
               enc_en       = 1'b1;
               // a second value that is not a low surrogate spoils the pair
               enc_cp       = (acc_next >= 16'hDC00 && acc_next <= 16'hDFFF) ?
                              CP_SUPP + 21'({high_half_ff, acc_next[9:0]}) : CP_REPL;
               phase_in     = PH_BODY;
            end else begin
               hex_count_in = hex_count_ff + 2'd1;
               code_acc_in  = acc_next;
            end
         end
         default: begin
            // idle, and the unused phase code
            if (c == CH_QUOTE) begin
               phase_in     = PH_BODY;
               hex_count_in = '0;
               code_acc_in  = '0;
               high_half_in = '0;
            end else begin
               use_step = 1'b1;
            end
         end
      endcase

      if (use_step) begin
         if (st.to_idle) begin
            phase_in     = PH_IDLE;
            hex_count_in = '0;
            code_acc_in  = '0;
            high_half_in = '0;
         end else begin
            phase_in = st.next_phase;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Result group assembly
   // --------------------------------------------------------------------------
   always_comb begin
      enc   = utf8_encode(enc_cp);
      enc_n = enc_en ? enc.n : 3'd0;
      res_n = enc_n + {2'b0, use_step && st.one_en};
      for (int i = 0; i < GROUP_MAX; i++) begin
         if (3'(i) < enc_n) begin
            grp[i].out_byte = enc.bytes[i];
            grp[i].kind     = jsu_pkg::KIND_BYTE;
         end else begin
            grp[i].out_byte = (st.kind == jsu_pkg::KIND_BYTE) ? st.one_byte : 8'h00;
            grp[i].kind     = st.kind;
         end
         grp[i].last = (3'(i) == res_n - 3'd1);
         wr_idx[i]   = wr_ptr_ff + PTR_W'(i);
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(res_n);
         count_in  = count_in + CNT_W'(res_n);
      end
      if (rsp_take) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   // --------------------------------------------------------------------------
   // Registers
   // --------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hex_count_ff <= '0;
         code_acc_ff  <= '0;
         high_half_ff <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (req_take) begin
            phase_ff     <= phase_in;
            hex_count_ff <= hex_count_in;
            code_acc_ff  <= code_acc_in;
            high_half_ff <= high_half_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int i = 0; i < GROUP_MAX; i++) begin
            if (3'(i) < res_n) begin
               fifo_ff[wr_idx[i]] <= grp[i];
            end
         end
      end
   end

endmodule
